// File: rtl/hvns_pkg.sv
// ----------------------------------------------------------------------------
// hvns_pkg
// Shared types, hash constants and the seed key helper for the hashed
// value noise smoother.
// ----------------------------------------------------------------------------
package hvns_pkg;

   typedef logic [31:0] hash_type;
   typedef logic signed [31:0] coord_type;
   typedef logic [23:0] cell_type;
   typedef logic [25:0] row_type;
   typedef logic [27:0] noise_type;

   // seed/coordinate mix and finalizer constants
   localparam hash_type MixGolden = 32'h9E37_79B9;
   localparam hash_type MixXAdd   = 32'h85EB_CA6B;
   localparam hash_type MixYAdd   = 32'hC2B2_AE35;
   localparam hash_type FinMulA   = 32'h7FEB_352D;
   localparam hash_type FinMulB   = 32'h846C_A68B;

   // neighbour offsets: -1, 0, +1 (wrap modulo 2^32)
   localparam hash_type Offset [3] = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001};

   localparam int NeighborCount = 9;

   // largest possible weighted sum, 16 * (2^24 - 1)
   localparam noise_type NoiseMax = 28'd268435440;

   // register file decode
   localparam int CsrAddrWidth = 3;
   localparam int CsrIndexBit  = 2;
   localparam logic RegNoiseSeed = 1'b0;

   // seed-only part of the hash, fixed between seed writes
   typedef struct packed {
      hash_type h0;   // seed ^ golden
      hash_type k0;   // XADD + (h0 << 6) + (h0 >> 2)
   } key_type;

   function automatic key_type mix_key(input hash_type seed);
      key_type key;
      key.h0 = seed ^ MixGolden;
      key.k0 = MixXAdd + (key.h0 << 6) + (key.h0 >> 2);
      return key;
   endfunction

endpackage

// File: rtl/hvns_if.sv
// ----------------------------------------------------------------------------
// hvns_req_if / hvns_rsp_if
// Valid/ready channels for coordinate words in and noise words out.
// ----------------------------------------------------------------------------
interface hvns_req_if;
   logic                valid;
   logic                ready;
   hvns_pkg::coord_type x_coord;
   hvns_pkg::coord_type y_coord;

   modport source (output valid, output x_coord, output y_coord, input ready);
   modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface hvns_rsp_if;
   logic                valid;
   logic                ready;
   hvns_pkg::noise_type noise_value;

   modport source (output valid, output noise_value, input ready);
   modport sink   (input valid, input noise_value, output ready);
endinterface

// File: rtl/hvns_csr.sv
// ----------------------------------------------------------------------------
// hvns_csr
// APB register file: holds noise_seed and its precomputed hash key.
// ----------------------------------------------------------------------------
module hvns_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [hvns_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready,
   output hvns_pkg::key_type                    key
);

   hvns_pkg::hash_type seed_ff;
   hvns_pkg::key_type  key_ff;
   logic               seed_sel;
   logic               wr_en;

   assign csr_pready = 1'b1;
   assign seed_sel   = (csr_paddr[hvns_pkg::CsrIndexBit] == hvns_pkg::RegNoiseSeed);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready && seed_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
         key_ff  <= hvns_pkg::mix_key('0);
      end else if (wr_en) begin
         seed_ff <= csr_pwdata;
         key_ff  <= hvns_pkg::mix_key(csr_pwdata);
      end
   end

   assign csr_prdata = seed_sel ? seed_ff : '0;
   assign key        = key_ff;

endmodule

// File: rtl/hvns_mix.sv
// ----------------------------------------------------------------------------
// hvns_mix
// Two stages: x mix for three columns, then y mix for all nine cells
// plus the first xor-shift of the finalizer.
// ----------------------------------------------------------------------------
module hvns_mix (
   input  logic                clock,
   input  logic                en,
   input  hvns_pkg::key_type   key,
   input  hvns_pkg::coord_type x_coord,
   input  hvns_pkg::coord_type y_coord,
   output hvns_pkg::hash_type  mix_out [hvns_pkg::NeighborCount]
);

   hvns_pkg::hash_type h1_in  [3];
   hvns_pkg::hash_type h1_ff  [3];
   hvns_pkg::hash_type yk_in  [3];
   hvns_pkg::hash_type yk_ff  [3];
   hvns_pkg::hash_type h2     [hvns_pkg::NeighborCount];
   hvns_pkg::hash_type mix_in [hvns_pkg::NeighborCount];
   hvns_pkg::hash_type mix_ff [hvns_pkg::NeighborCount];

   // stage 1: h1 = h0 ^ (x + k0), y pre-add
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         h1_in[i] = key.h0 ^ (hvns_pkg::hash_type'(x_coord) + key.k0 + hvns_pkg::Offset[i]);
         yk_in[i] = hvns_pkg::hash_type'(y_coord) + hvns_pkg::MixYAdd + hvns_pkg::Offset[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h1_ff <= h1_in;
         yk_ff <= yk_in;
      end
   end

   // stage 2: cell index = 3*row + column, row/column 0 is the -1 side
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         for (int i = 0; i < 3; i++) begin
            h2[3*j+i] = h1_ff[i] ^ (yk_ff[j] + (h1_ff[i] << 6) + (h1_ff[i] >> 2));
            mix_in[3*j+i] = h2[3*j+i] ^ (h2[3*j+i] >> 16);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mix_ff <= mix_in;
      end
   end

   assign mix_out = mix_ff;

endmodule

// File: rtl/hvns_fin.sv
// ----------------------------------------------------------------------------
// hvns_fin
// One finalizer lane: multiply, xor-shift, multiply, xor-shift, low 24 bits.
// Three stages: two multiplier stages, then an xor-shift and mask stage.
// ----------------------------------------------------------------------------
module hvns_fin (
   input  logic               clock,
   input  logic               en,
   input  hvns_pkg::hash_type mix,
   output hvns_pkg::cell_type lane_out
);

   hvns_pkg::hash_type m1_in;
   hvns_pkg::hash_type m1_ff;
   hvns_pkg::hash_type g;
   hvns_pkg::hash_type m2_in;
   hvns_pkg::hash_type m2_ff;
   hvns_pkg::hash_type h3;
   hvns_pkg::cell_type cell_ff;

   assign m1_in = hvns_pkg::hash_type'(mix * hvns_pkg::FinMulA);
   assign g     = m1_ff ^ (m1_ff >> 15);
   assign m2_in = hvns_pkg::hash_type'(g * hvns_pkg::FinMulB);
   assign h3    = m2_ff ^ (m2_ff >> 16);

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff   <= m1_in;
         m2_ff   <= m2_in;
         cell_ff <= h3[23:0];
      end
   end

   assign lane_out = cell_ff;

endmodule

// File: rtl/hvns_sum.sv
// ----------------------------------------------------------------------------
// hvns_sum
// 3x3 binomial weighting as two separable passes: rows 1-2-1, then
// columns 1-2-1. Two stages.
// ----------------------------------------------------------------------------
module hvns_sum (
   input  logic                clock,
   input  logic                en,
   input  hvns_pkg::cell_type  lane_in [hvns_pkg::NeighborCount],
   output hvns_pkg::noise_type noise
);

   hvns_pkg::row_type   row_in [3];
   hvns_pkg::row_type   row_ff [3];
   hvns_pkg::noise_type sum_in;
   hvns_pkg::noise_type sum_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         row_in[j] = {2'b00, lane_in[3*j]} + {1'b0, lane_in[3*j+1], 1'b0}
                   + {2'b00, lane_in[3*j+2]};
      end
   end

   assign sum_in = {2'b00, row_ff[0]} + {1'b0, row_ff[1], 1'b0} + {2'b00, row_ff[2]};

   always_ff @(posedge clock) begin
      if (en) begin
         row_ff <= row_in;
         sum_ff <= sum_in;
      end
   end

   assign noise = sum_ff;

endmodule

// File: rtl/hashed_value_noise_smoother_core.sv
// ----------------------------------------------------------------------------
// hashed_value_noise_smoother_core
// Smoothed value noise at a tile: nine seeded hashes, 3x3 binomial sum.
// ----------------------------------------------------------------------------
// Each word in carries a signed tile coordinate (x_coord, y_coord); each word
// out carries noise_value, the 1-2-1 x 1-2-1 weighted sum of the low 24 bits
// of the seeded hash at the tile and its eight neighbours (noise = value /
// 2^28, range 0..268435440). Neighbour coordinates wrap modulo 2^32. The block
// takes one word per clock with no bubbles while the skid register is empty;
// the word is captured into the first of seven pipeline stages (x mix, y mix,
// two multiplier stages and a mask stage in nine parallel finalizer lanes, row
// and column sums) and the output register follows the seventh. A skid register
// behind the output keeps rsp_bus.ready off the input path: a stall on the
// result side freezes the whole pipeline once a word has parked in the skid,
// nothing dropped or repeated. req_bus.ready is low during
// reset. noise_seed (register 0, byte address 0) is written over APB and
// should only change while no word is in flight.
// ----------------------------------------------------------------------------
module hashed_value_noise_smoother_core (
   input  logic                              clock,
   input  logic                              reset,
   hvns_req_if.sink                          req_bus,
   hvns_rsp_if.source                        rsp_bus,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [hvns_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   localparam int PipeDepth = 7;

   hvns_pkg::key_type   key;
   hvns_pkg::hash_type  mix  [hvns_pkg::NeighborCount];
   hvns_pkg::cell_type  lane [hvns_pkg::NeighborCount];
   hvns_pkg::noise_type pipe_noise;

   logic                 en;
   logic [PipeDepth-1:0] valid_ff;
   logic [PipeDepth-1:0] valid_in;
   logic                 pipe_valid;

   logic                 out_valid_ff;
   hvns_pkg::noise_type  out_noise_ff;
   logic                 skid_valid_ff;
   hvns_pkg::noise_type  skid_noise_ff;

   // ---- register file -----------------------------------------------------
   hvns_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .key         (key)
   );

   // ---- pipeline control --------------------------------------------------
   // Whole pipe advances together; it only holds while the skid is occupied,
   // which is a registered condition, so ready never sees rsp_bus.ready.
   assign en            = !skid_valid_ff;
   assign req_bus.ready = en && !reset;

   // valid bits travel with the data, one per stage
   assign valid_in   = {valid_ff[PipeDepth-2:0], req_bus.valid};
   assign pipe_valid = valid_ff[PipeDepth-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   // ---- datapath ----------------------------------------------------------
   // stages 1-2
   hvns_mix u_mix (
      .clock   (clock),
      .en      (en),
      .key     (key),
      .x_coord (req_bus.x_coord),
      .y_coord (req_bus.y_coord),
      .mix_out (mix)
   );

   // stages 3-5, one lane per cell of the 3x3 window
   for (genvar n = 0; n < hvns_pkg::NeighborCount; n++) begin : g_fin
      hvns_fin u_fin (
         .clock    (clock),
         .en       (en),
         .mix      (mix[n]),
         .lane_out (lane[n])
      );
   end

   // stages 6-7
   hvns_sum u_sum (
      .clock   (clock),
      .en      (en),
      .lane_in (lane),
      .noise   (pipe_noise)
   );

   // ---- output register and skid -----------------------------------------
   // Output register empties or is taken: refill from skid first, else
   // from the pipe. Output held: a word leaving the pipe parks in the skid.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_bus.ready || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= pipe_valid;
         end
      end else if (en && pipe_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_bus.ready || !out_valid_ff) begin
         out_noise_ff <= skid_valid_ff ? skid_noise_ff : pipe_noise;
      end else if (en && pipe_valid) begin
         skid_noise_ff <= pipe_noise;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.noise_value = out_noise_ff;

   // ---- assertions --------------------------------------------------------
   // skid only fills behind a held output word
   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word present with empty output register");

   // a parked word stays parked until the output side moves
   a_skid_kept : assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_bus.ready) |=> (skid_valid_ff && $stable(skid_noise_ff)))
      else $error("skid word lost during stall");

   // weighted sum never exceeds 16 * (2^24 - 1)
   a_noise_range : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_noise_ff <= hvns_pkg::NoiseMax))
      else $error("noise value out of range");

endmodule
